>>> sv/assert_macros.svh
// Concurrent assertion helpers clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASSERT_CLK(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// The expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

>>> sv/psq_pkg.sv
package psq_pkg;

	localparam int PHASE_BITS = 24;
	localparam int IN_BITS = 24;
	localparam int Q_BITS = 15;
	localparam int SQ_BITS = Q_BITS + 1;
	localparam int RES_BITS = Q_BITS + 2;
	localparam int SUM_BITS = RES_BITS + 1;
	localparam int CNT_BITS = $clog2(Q_BITS);

	typedef logic [PHASE_BITS-1:0] phase_t;
	typedef logic [IN_BITS-1:0] q24_t;
	typedef logic signed [RES_BITS-1:0] res_t;
	typedef logic [CNT_BITS-1:0] cnt_t;

	localparam q24_t HALF_IN = q24_t'(1) << (IN_BITS - 1);
	localparam logic [PHASE_BITS:0] PHASE_ONE = (PHASE_BITS + 1)'(1) << PHASE_BITS;
	localparam logic [SQ_BITS-1:0] Q15_ONE = SQ_BITS'(1) << Q_BITS;
	localparam cnt_t LAST_STEP = cnt_t'(Q_BITS - 1);
	localparam logic signed [SUM_BITS-1:0] OUT_MAX = SUM_BITS'(65535);
	localparam logic signed [SUM_BITS-1:0] OUT_MIN = -SUM_BITS'(65536);
	localparam logic signed [SUM_BITS-1:0] LEVEL = SUM_BITS'(32768);

	// Rescale a Q0.24 fraction to the accumulator width.
	function automatic phase_t to_phase(input q24_t v);
		logic [PHASE_BITS+IN_BITS-1:0] wide;
		wide = {v, PHASE_BITS'(0)};
		return wide[PHASE_BITS+IN_BITS-1:IN_BITS];
	endfunction

endpackage

>>> sv/psq_edge.sv
`include "assert_macros.svh"

module psq_edge (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  psq_pkg::phase_t t,
	input  psq_pkg::phase_t dt,
	output logic           done,
	output psq_pkg::res_t  residual
);
	import psq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_SQR  = 3'b100
	} state_t;

	state_t state_q;
	cnt_t cnt_q;
	phase_t r_q;
	phase_t dt_q;
	logic [Q_BITS-1:0] quo_q;
	logic [SQ_BITS-1:0] sq_q;
	logic lo_q;
	logic hi_q;
	logic done_q;

	logic lo;
	logic hi;
	logic [PHASE_BITS:0] sum_td;
	logic [PHASE_BITS:0] r2;
	logic [PHASE_BITS:0] r2_sub;
	logic ge;
	logic [SQ_BITS-1:0] w;
	logic [2*SQ_BITS-1:0] prod;
	res_t sq_ext;

	assign sum_td = {1'b0, t} + {1'b0, dt};
	assign lo = (dt != '0) && (t < dt);
	assign hi = (dt != '0) && !lo && (sum_td > PHASE_ONE);

	assign r2 = {r_q, 1'b0};
	assign r2_sub = r2 - {1'b0, dt_q};
	assign ge = r2 >= {1'b0, dt_q};

	assign w = Q15_ONE - {1'b0, quo_q};
	assign prod = w * w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == LAST_STEP) begin
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					lo_q <= lo;
					hi_q <= hi;
					dt_q <= dt;
					r_q <= lo ? t : phase_t'(-t);
					quo_q <= '0;
					cnt_q <= '0;
				end
			end
			S_DIV: begin
				r_q <= ge ? r2_sub[PHASE_BITS-1:0] : r2[PHASE_BITS-1:0];
				quo_q <= {quo_q[Q_BITS-2:0], ge};
				cnt_q <= cnt_q + cnt_t'(1);
			end
			S_SQR: begin
				sq_q <= prod[2*Q_BITS:Q_BITS];
			end
			default: begin
			end
		endcase
	end

	assign sq_ext = {1'b0, sq_q};
	assign residual = lo_q ? -sq_ext : (hi_q ? sq_ext : '0);
	assign done = done_q;

	`ASSERT_NEVER(a_one_window, (state_q != S_IDLE) && lo_q && hi_q)
	`ASSERT_CLK(a_rem_below_step, (state_q == S_DIV && (lo_q || hi_q)) |-> (r_q < dt_q))
	`ASSERT_CLK(a_done_from_square, done_q |-> (state_q == S_IDLE))

endmodule

>>> sv/polyblep_square_oscillator_top.sv
// Channel  Handshake                 Payload
// in       in_valid / in_stall       phase_step, load_phase, phase_value
// out      out_valid / out_stall     sample
//
// Each item passes from acceptance through the edge units to the output register: the
// 15-step restoring divide in each edge unit comes first, then the square, then the load of
// the output register. The next transaction is accepted on the cycle after that load.
// While an earlier sample waits on a stalled output, a finished result stays in the edge
// units and the input stays stalled until the output transaction completes.
// Reset clears the phase accumulator to zero and empties the output register.
`include "assert_macros.svh"

module polyblep_square_oscillator_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  psq_pkg::q24_t        phase_step,
	input  logic                 load_phase,
	input  psq_pkg::q24_t        phase_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [16:0]   sample
);
	import psq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_BUSY = 3'b010,
		S_WAIT = 3'b100
	} state_t;

	state_t state_q;
	phase_t phase_q;
	logic sign_q;
	logic out_valid_q;
	logic signed [RES_BITS-1:0] sample_q;

	logic accept;
	logic take;
	logic ready;
	q24_t step_sat;
	phase_t dt;
	phase_t t_cur;
	phase_t t_half;
	logic done_a;
	logic done_b;
	res_t res_a;
	res_t res_b;
	logic signed [SUM_BITS-1:0] sum;
	logic signed [RES_BITS-1:0] sat;

	assign accept = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign take = out_valid_q && !out_stall;

	assign step_sat = (phase_step > HALF_IN) ? HALF_IN : phase_step;
	assign dt = to_phase(step_sat);
	assign t_cur = load_phase ? to_phase(phase_value) : phase_q;
	assign t_half = {~t_cur[PHASE_BITS-1], t_cur[PHASE_BITS-2:0]};

	psq_edge u_edge_rise (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.t(t_cur),
		.dt(dt),
		.done(done_a),
		.residual(res_a)
	);

	psq_edge u_edge_fall (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.t(t_half),
		.dt(dt),
		.done(done_b),
		.residual(res_b)
	);

	assign sum = (sign_q ? -LEVEL : LEVEL) + SUM_BITS'(res_a) - SUM_BITS'(res_b);

	always_comb begin
		if (sum > OUT_MAX) begin
			sat = OUT_MAX[RES_BITS-1:0];
		end else if (sum < OUT_MIN) begin
			sat = OUT_MIN[RES_BITS-1:0];
		end else begin
			sat = sum[RES_BITS-1:0];
		end
	end

	assign ready = (state_q == S_BUSY && done_a) || (state_q == S_WAIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						phase_q <= t_cur + dt;
						state_q <= S_BUSY;
					end
				end
				S_BUSY, S_WAIT: begin
					if (ready && (!out_valid_q || take)) begin
						state_q <= S_IDLE;
					end else if (ready) begin
						state_q <= S_WAIT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (ready && (!out_valid_q || take)) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sign_q <= t_cur[PHASE_BITS-1];
		end
		if (ready && (!out_valid_q || take)) begin
			sample_q <= sat;
		end
	end

	assign out_valid = out_valid_q;
	assign sample = sample_q;

	`ASSERT_CLK(a_edges_in_step, done_a == done_b)
	`ASSERT_CLK(a_done_when_busy, done_a |-> (state_q == S_BUSY))
	`ASSERT_CLK(a_wait_has_output, (state_q == S_WAIT) |-> out_valid_q)

endmodule

>>> dv/psq_sample_checker.sv
module psq_sample_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  psq_pkg::q24_t       phase_step,
	input  logic                load_phase,
	input  psq_pkg::q24_t       phase_value,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic signed [16:0]  sample,
	output int                  mismatches,
	output int                  pending_results
);
	timeunit 1ns;
	timeprecision 1ps;
	import psq_pkg::*;

	localparam phase_t HALF_CYCLE = phase_t'(1) << (PHASE_BITS - 1);

	phase_t osc_phase;
	phase_t tick_step;
	phase_t tick_phase;
	logic signed [16:0] expected_samples[$];
	logic signed [16:0] oldest_sample;

	function automatic longint blep_residual(input phase_t t, input phase_t dt);
		longint unsigned one_cycle;
		longint unsigned gap;
		longint unsigned q;
		longint unsigned w;
		one_cycle = longint'(1) << PHASE_BITS;
		if (dt == '0) begin
			return 0;
		end
		if (t < dt) begin
			gap = t;
			q = (gap << 15) / dt;
			w = 32768 - q;
			return -longint'((w * w) >> 15);
		end
		if (longint'(t) > one_cycle - dt) begin
			gap = one_cycle - t;
			q = (gap << 15) / dt;
			w = 32768 - q;
			return longint'((w * w) >> 15);
		end
		return 0;
	endfunction

	function automatic logic signed [16:0] square_sample(input phase_t t, input phase_t dt);
		phase_t t_half;
		longint level;
		t_half = t + HALF_CYCLE;
		level = (t < HALF_CYCLE) ? 32768 : -32768;
		level = level + blep_residual(t, dt) - blep_residual(t_half, dt);
		if (level > 65535) begin
			level = 65535;
		end
		if (level < -65536) begin
			level = -65536;
		end
		return level[16:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_phase <= '0;
			expected_samples.delete();
			mismatches = 0;
			pending_results = 0;
		end else begin
			if (in_valid && !in_stall) begin
				tick_step = (phase_step > HALF_IN) ? HALF_IN : phase_step;
				tick_phase = load_phase ? phase_value : osc_phase;
				expected_samples.push_back(square_sample(tick_phase, tick_step));
				osc_phase <= tick_phase + tick_step;
			end
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected output transaction: sample %0d", sample);
					end
				end else begin
					oldest_sample = expected_samples.pop_front();
					if (sample !== oldest_sample) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("sample mismatch: expected %0d, got %0d",
								oldest_sample, sample);
						end
					end
				end
			end
			pending_results = expected_samples.size();
		end
	end

endmodule

>>> dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import psq_pkg::*;

	localparam int TOTAL_RANDOM = 500;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	q24_t phase_step = '0;
	logic load_phase = 1'b0;
	q24_t phase_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [16:0] sample;

	int mismatches;
	int pending_results;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	polyblep_square_oscillator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.phase_step(phase_step),
		.load_phase(load_phase),
		.phase_value(phase_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample(sample)
	);

	psq_sample_checker sample_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.phase_step(phase_step),
		.load_phase(load_phase),
		.phase_value(phase_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample(sample),
		.mismatches(mismatches),
		.pending_results(pending_results)
	);

	always @(posedge clk) begin
		out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL polyblep_square_oscillator_top");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_tick(input q24_t step, input logic load, input q24_t value);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			phase_step <= q24_t'($urandom);
			load_phase <= 1'($urandom);
			phase_value <= q24_t'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		phase_step <= step;
		load_phase <= load;
		phase_value <= value;
		do @(posedge clk); while (in_stall);
	endtask

	function automatic q24_t pick_step();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10) begin
			return '0;
		end else if (sel < 50) begin
			return q24_t'($urandom_range(24'h200000, 24'h000100));
		end else if (sel < 70) begin
			return q24_t'($urandom_range(24'h800000, 24'h200000));
		end else if (sel < 80) begin
			return q24_t'($urandom_range(24'hFFFFFF, 24'h800000));
		end
		return q24_t'($urandom);
	endfunction

	function automatic q24_t pick_load_phase(input q24_t step);
		q24_t offset;
		q24_t base;
		if ($urandom_range(1) == 0) begin
			return q24_t'($urandom);
		end
		offset = q24_t'($urandom_range(int'((step > HALF_IN) ? HALF_IN : step)));
		base = ($urandom_range(1) == 0) ? q24_t'(0) : HALF_IN;
		return ($urandom_range(1) == 0) ? base + offset : base - offset;
	endfunction

	initial begin
		int sent;
		int burst_len;
		q24_t burst_step;
		q24_t step;
		logic load;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick(24'h000000, 1'b1, 24'h000000);
		send_tick(24'h000000, 1'b0, 24'h000000);
		send_tick(24'h000000, 1'b1, 24'h800000);
		send_tick(24'h800000, 1'b1, 24'h000000);
		send_tick(24'h800000, 1'b0, 24'h000000);
		send_tick(24'h800000, 1'b0, 24'h000000);
		send_tick(24'hFFFFFF, 1'b1, 24'hFFFFFF);
		send_tick(24'hFFFFFF, 1'b0, 24'h000000);
		send_tick(24'h800001, 1'b1, 24'h800000);
		send_tick(24'h000001, 1'b1, 24'h000000);
		send_tick(24'h000001, 1'b1, 24'hFFFFFF);
		send_tick(24'h000001, 1'b1, 24'h7FFFFF);
		send_tick(24'h000001, 1'b1, 24'h800000);
		send_tick(24'h400000, 1'b1, 24'h3FFFFF);
		send_tick(24'h400000, 1'b1, 24'hC00001);
		send_tick(24'h000100, 1'b1, 24'h0000FF);
		send_tick(24'h000100, 1'b1, 24'hFFFF01);
		send_tick(24'h000100, 1'b1, 24'h7FFF80);
		send_tick(24'h000100, 1'b1, 24'h800080);
		send_tick(24'hAAAAAA, 1'b1, 24'h555555);
		send_tick(24'h555555, 1'b1, 24'hAAAAAA);
		send_tick(24'h123456, 1'b0, 24'hFFFFFF);

		// Random part: bursts of steady tones with occasional phase loads and step noise.
		sent = 0;
		while (sent < TOTAL_RANDOM) begin
			burst_len = $urandom_range(30, 5);
			burst_step = pick_step();
			for (int k = 0; k < burst_len && sent < TOTAL_RANDOM; k++) begin
				case ((sent / 25) % 4)
					0: begin
						sender_idle_pct = 0;
						receiver_stall_pct = 0;
					end
					1: begin
						sender_idle_pct = 62;
						receiver_stall_pct = 0;
					end
					2: begin
						sender_idle_pct = 0;
						receiver_stall_pct = 62;
					end
					default: begin
						sender_idle_pct = 30;
						receiver_stall_pct = 30;
					end
				endcase
				step = ($urandom_range(99) < 10) ? q24_t'($urandom) : burst_step;
				load = ($urandom_range(99) < 12);
				send_tick(step, load, load ? pick_load_phase(step) : q24_t'($urandom));
				sent++;
			end
		end

		in_valid <= 1'b0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (25) @(posedge clk);
		if (mismatches == 0 && pending_results == 0) begin
			$display("PASS polyblep_square_oscillator_top");
		end else begin
			$display("FAIL polyblep_square_oscillator_top");
		end
		$finish;
	end

endmodule
